// ===== src/wavcp_pkg.sv =====
// wavcp_pkg: result record, result kinds, error codes and RIFF/WAVE tag constants
// shared by the WAV chunk parser, its output stage and its port checker.
// Depends on nothing.
package wavcp_pkg;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_AUDIO  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NOT_WAV       = 2'd0;
  localparam logic [1:0] ERR_DATA_NO_FMT   = 2'd1;
  localparam logic [1:0] ERR_EARLY_END     = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BASE_LEN    = 32'd16;
  localparam logic [2:0]  FMT_MIDDLE_SKIP = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic        audio_last;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ===== src/wavcp_out_stage.sv =====
// wavcp_out_stage: one-entry result register with valid/ready handshake.
// Depends on wavcp_pkg (result_t).
module wavcp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  wavcp_pkg::result_t load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output wavcp_pkg::result_t out_data
);

  logic               valid_r;
  wavcp_pkg::result_t data_r;

  // free when empty or when the held item leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

// ===== src/wav_chunk_parser.sv =====
// wav_chunk_parser: byte-serial RIFF/WAVE header parser and audio byte passer.
// Depends on wavcp_pkg and wavcp_out_stage.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-----------
//  in      | in_data_byte, in_file_end               | into      | in_valid / in_ready
//  out     | out_kind, out_audio_byte, out_audio_last,| out of    | out_valid / out_ready
//          | out_channel_count, out_rate_hz,         |           |
//          | out_sample_bits, out_data_length,       |           |
//          | out_error_code                          |           |
//
// Cycles: one byte per clock while in_ready is high. Each accepted byte updates the parser
//   state in the same edge and any result it causes lands in the output register, visible
//   the next cycle; the output register is the only stage.
// Reset: rst_n low clears the parser to "expect RIFF tag" and empties the output.
// Stalls: in_ready follows the output register; it stays high while the register
//   is empty or its item is taken this cycle, so a waiting result still lets the
//   next byte in whenever the consumer is taking items.
// A byte with in_file_end set re-arms the parser after its own processing.
module wav_chunk_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_audio_byte,
  output logic        out_audio_last,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_rate_hz,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_data_length,
  output logic [1:0]  out_error_code
);

  // parser phases; codes above PH_HALT act like PH_HALT
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_FSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FFMT  = 4'd5,
    PH_FCH   = 4'd6,
    PH_FRATE = 4'd7,
    PH_FMID  = 4'd8,
    PH_FBITS = 4'd9,
    PH_SKIP  = 4'd10,
    PH_DATA  = 4'd11,
    PH_DONE  = 4'd12,
    PH_HALT  = 4'd13
  } phase_t;

  phase_t      phase_r,    phase_nxt;
  logic [2:0]  fbi_r,      fbi_nxt;
  logic [31:0] tag_r,      tag_nxt;
  logic [31:0] clen_r,     clen_nxt;
  logic [31:0] skip_r,     skip_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] chans_r,    chans_nxt;
  logic [31:0] rate_r,     rate_nxt;
  logic [15:0] bits_r,     bits_nxt;
  logic [31:0] dleft_r,    dleft_nxt;

  logic               in_fire;
  logic               stage_free;
  logic               res_vld;
  wavcp_pkg::result_t res;
  wavcp_pkg::result_t out_data;

  // field counter helpers
  logic       in_field;
  logic [2:0] fld_len;
  logic [2:0] idx_inc;
  logic       fld_done;
  logic [31:0] skip_dec;
  logic [31:0] dleft_dec;

  assign in_ready = stage_free;
  assign in_fire  = in_valid && in_ready;

  assign idx_inc   = fbi_r + 3'd1;
  assign skip_dec  = skip_r - 32'd1;
  assign dleft_dec = dleft_r - 32'd1;

  // byte length of the multi-byte field read in each phase
  always_comb begin
    in_field = 1'b1;
    case (phase_r)
      PH_RIFF, PH_FSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FRATE: fld_len = 3'd4;
      PH_FFMT, PH_FCH, PH_FBITS:                              fld_len = 3'd2;
      PH_FMID:                                                fld_len = wavcp_pkg::FMT_MIDDLE_SKIP;
      default: begin
        fld_len  = 3'd0;
        in_field = 1'b0;
      end
    endcase
  end

  assign fld_done = in_field && (idx_inc >= fld_len);

  always_comb begin
    phase_nxt    = phase_r;
    fbi_nxt      = fbi_r;
    tag_nxt      = tag_r;
    clen_nxt     = clen_r;
    skip_nxt     = skip_r;
    fmt_seen_nxt = fmt_seen_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    dleft_nxt    = dleft_r;
    res          = '0;
    res_vld      = 1'b0;

    if (in_field) begin
      fbi_nxt = fld_done ? 3'd0 : idx_inc;
    end

    case (phase_r)
      PH_RIFF, PH_WAVE, PH_CID: begin
        // shift tag bytes in big-endian order
        tag_nxt = {tag_r[23:0], in_data_byte};
        if (fld_done) begin
          if (phase_r == PH_RIFF) begin
            if (tag_nxt != wavcp_pkg::TAG_RIFF) begin
              res.kind       = wavcp_pkg::KIND_ERROR;
              res.error_code = wavcp_pkg::ERR_NOT_WAV;
              res_vld        = 1'b1;
              phase_nxt      = PH_HALT;
            end else begin
              phase_nxt = PH_FSIZE;
            end
          end else if (phase_r == PH_WAVE) begin
            if (tag_nxt != wavcp_pkg::TAG_WAVE) begin
              res.kind       = wavcp_pkg::KIND_ERROR;
              res.error_code = wavcp_pkg::ERR_NOT_WAV;
              res_vld        = 1'b1;
              phase_nxt      = PH_HALT;
            end else begin
              phase_nxt = PH_CID;
            end
          end else begin
            phase_nxt = PH_CSIZE;
          end
        end
      end
      PH_FSIZE: begin
        if (fld_done) phase_nxt = PH_WAVE;
      end
      PH_CSIZE: begin
        // little-endian size: shift in from the top
        clen_nxt = {in_data_byte, clen_r[31:8]};
        if (fld_done) begin
          if (tag_r == wavcp_pkg::TAG_FMT) begin
            phase_nxt = PH_FFMT;
          end else if (tag_r == wavcp_pkg::TAG_DATA) begin
            if (!fmt_seen_r) begin
              res.kind       = wavcp_pkg::KIND_ERROR;
              res.error_code = wavcp_pkg::ERR_DATA_NO_FMT;
              res_vld        = 1'b1;
              phase_nxt      = PH_HALT;
            end else begin
              res.kind          = wavcp_pkg::KIND_FORMAT;
              res.channel_count = chans_r;
              res.rate_hz       = rate_r;
              res.sample_bits   = bits_r;
              res.data_length   = clen_nxt;
              res_vld           = 1'b1;
              dleft_nxt         = clen_nxt;
              phase_nxt         = (clen_nxt != 32'd0) ? PH_DATA : PH_DONE;
            end
          end else begin
            skip_nxt  = clen_nxt;
            phase_nxt = (clen_nxt != 32'd0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FFMT: begin
        if (fld_done) phase_nxt = PH_FCH;
      end
      PH_FCH: begin
        chans_nxt = {in_data_byte, chans_r[15:8]};
        if (fld_done) phase_nxt = PH_FRATE;
      end
      PH_FRATE: begin
        rate_nxt = {in_data_byte, rate_r[31:8]};
        if (fld_done) phase_nxt = PH_FMID;
      end
      PH_FMID: begin
        if (fld_done) phase_nxt = PH_FBITS;
      end
      PH_FBITS: begin
        bits_nxt = {in_data_byte, bits_r[15:8]};
        if (fld_done) begin
          fmt_seen_nxt = 1'b1;
          // skip whatever the fmt chunk holds past its base 16 bytes
          if (clen_r > wavcp_pkg::FMT_BASE_LEN) begin
            skip_nxt  = clen_r - wavcp_pkg::FMT_BASE_LEN;
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_CID;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) phase_nxt = PH_CID;
      end
      PH_DATA: begin
        res.kind       = wavcp_pkg::KIND_AUDIO;
        res.audio_byte = in_data_byte;
        res.audio_last = (dleft_r == 32'd1);
        res_vld        = 1'b1;
        dleft_nxt      = dleft_dec;
        if (dleft_dec == 32'd0) phase_nxt = PH_DONE;
      end
      default: begin
        // done, halted or unused code: drop the byte
      end
    endcase

    if (in_file_end) begin
      // file ended before the data chunk was reached
      if (!res_vld && (phase_nxt <= PH_SKIP)) begin
        res            = '0;
        res.kind       = wavcp_pkg::KIND_ERROR;
        res.error_code = wavcp_pkg::ERR_EARLY_END;
        res_vld        = 1'b1;
      end
      // re-arm for the next file
      phase_nxt    = PH_RIFF;
      fbi_nxt      = '0;
      tag_nxt      = '0;
      clen_nxt     = '0;
      skip_nxt     = '0;
      fmt_seen_nxt = 1'b0;
      chans_nxt    = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
      dleft_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      fbi_r      <= '0;
      tag_r      <= '0;
      clen_r     <= '0;
      skip_r     <= '0;
      fmt_seen_r <= 1'b0;
      chans_r    <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      dleft_r    <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      fbi_r      <= fbi_nxt;
      tag_r      <= tag_nxt;
      clen_r     <= clen_nxt;
      skip_r     <= skip_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      dleft_r    <= dleft_nxt;
    end
  end

  // hold the result until the consumer takes it
  wavcp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_fire && res_vld),
    .load_data  (res),
    .can_load   (stage_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_audio_byte    = out_data.audio_byte;
  assign out_audio_last    = out_data.audio_last;
  assign out_channel_count = out_data.channel_count;
  assign out_rate_hz       = out_data.rate_hz;
  assign out_sample_bits   = out_data.sample_bits;
  assign out_data_length   = out_data.data_length;
  assign out_error_code    = out_data.error_code;

endmodule

// ===== src/wavcp_checker.sv =====
// wavcp_checker: port-level assertions for wav_chunk_parser, bound into wav_chunk_parser.
// Depends on wavcp_pkg (result kinds and error codes).
module wavcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_audio_byte,
  input logic        out_audio_last,
  input logic [15:0] out_channel_count,
  input logic [31:0] out_rate_hz,
  input logic [15:0] out_sample_bits,
  input logic [31:0] out_data_length,
  input logic [1:0]  out_error_code
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_audio_byte)
      && $stable(out_audio_last) && $stable(out_data_length) && $stable(out_error_code))
    else $error("result changed while stalled");

  // an empty output never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // only defined kinds appear
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == wavcp_pkg::KIND_FORMAT || out_kind == wavcp_pkg::KIND_AUDIO
      || out_kind == wavcp_pkg::KIND_ERROR))
    else $error("illegal result kind");

  // the checked fields that do not belong to the kind stay zero; error codes must be defined ones
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wavcp_pkg::KIND_ERROR |->
      !out_audio_last && out_rate_hz == 32'd0 && out_data_length == 32'd0
      && (out_error_code == wavcp_pkg::ERR_NOT_WAV
       || out_error_code == wavcp_pkg::ERR_DATA_NO_FMT
       || out_error_code == wavcp_pkg::ERR_EARLY_END))
    else $error("malformed error result");

  a_audio_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wavcp_pkg::KIND_AUDIO |->
      out_channel_count == 16'd0 && out_sample_bits == 16'd0 && out_error_code == 2'd0)
    else $error("malformed audio result");

endmodule

bind wav_chunk_parser wavcp_checker u_wavcp_checker (.*);
